// ----- rtl/ttag_pkg.sv -----
// ----------------------------------------------------------------------------
// ttag_pkg
// Shared codes, widths and item types of the transaction tag allocator.
// ----------------------------------------------------------------------------
package ttag_pkg;

    // Default sizes
    localparam int TAG_COUNT_DEF   = 256;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF    = 16;

    // Fixed port field widths
    localparam int CMD_W   = 2;
    localparam int TAG_W   = 8;
    localparam int REQ_W   = 16;
    localparam int EVENT_W = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NEW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TMO  = 2'd2;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_ISSUED    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_QUEUED    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_COMPLETED = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TIMED_OUT = 3'd3;
    localparam logic [EVENT_W-1:0] EV_IGNORED   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_DROPPED   = 3'd5;

    // Classification made by the front end
    typedef struct packed {
        logic is_new;   // new request
        logic is_rel;   // response or timeout naming an in-range tag
        logic is_tmo;   // timeout (valid with is_rel)
    } t_cls;

    // Item between front and back
    typedef struct packed {
        t_cls             cls;
        logic [TAG_W-1:0] tag;
        logic [REQ_W-1:0] req;
    } t_item;

    // Result item
    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [TAG_W-1:0]   tag;
        logic [REQ_W-1:0]   req;
        logic               last;
    } t_res;

endpackage

// ----- rtl/ttag_front.sv -----
// ----------------------------------------------------------------------------
// ttag_front
// Accepts input items, classifies the command and holds them in a two-entry
// queue in front of the allocation engine.
// ----------------------------------------------------------------------------
module ttag_front #(
    parameter int TAG_COUNT = ttag_pkg::TAG_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [ttag_pkg::CMD_W-1:0]    i_command,
    input  logic [ttag_pkg::TAG_W-1:0]    i_tag,
    input  logic [ttag_pkg::REQ_W-1:0]    i_request_id,
    output logic                          o_valid,
    output ttag_pkg::t_item               o_item,
    input  logic                          i_take
);

    localparam int DEPTH = 2;

    ttag_pkg::t_item r_q [DEPTH];
    logic            r_head;
    logic            r_tail;
    logic [1:0]      r_cnt;
    ttag_pkg::t_item w_in;
    logic            w_in_rng;
    logic            w_acc;

    // Classify the incoming command
    always_comb begin
        w_in_rng       = ({1'b0, i_tag} < 9'(TAG_COUNT));
        w_in.cls.is_new = (i_command == ttag_pkg::CMD_NEW);
        w_in.cls.is_rel = w_in_rng && ((i_command == ttag_pkg::CMD_RESP) ||
                                       (i_command == ttag_pkg::CMD_TMO));
        w_in.cls.is_tmo = (i_command == ttag_pkg::CMD_TMO);
        w_in.tag        = i_tag;
        w_in.req        = i_request_id;
    end

    assign w_acc   = i_push && !o_full;
    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_head];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_tail] <= w_in;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_acc) begin
                r_tail <= ~r_tail;
            end
            if (i_take) begin
                r_head <= ~r_head;
            end
            r_cnt <= r_cnt + 2'(w_acc) - 2'(i_take);
        end
    end

`ifndef NO_ASSERTIONS
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> o_valid) else $error("front: take from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(DEPTH)) else $error("front: count overflow");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_take) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("front: count not tracking accept");
`endif

endmodule

// ----- rtl/ttag_back.sv -----
// ----------------------------------------------------------------------------
// ttag_back
// Allocation engine: busy map, owner memory, wait queue and the windowed
// free-tag scan. Emits one or two result items per item taken.
// ----------------------------------------------------------------------------
module ttag_back #(
    parameter int TAG_COUNT   = ttag_pkg::TAG_COUNT_DEF,
    parameter int QUEUE_DEPTH = ttag_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ttag_pkg::ID_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ttag_pkg::t_item i_item,
    output logic            o_take,
    input  logic            i_room,
    output logic            o_res_valid,
    output ttag_pkg::t_res  o_res
);

    localparam int TW   = $clog2(TAG_COUNT);
    localparam int BW   = $clog2(TAG_COUNT + 1);
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int WIN  = (TAG_COUNT < 16) ? TAG_COUNT : 16;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RDOWN = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [1:0]          r_state;
    logic [TAG_COUNT-1:0] r_busy;
    logic [BW-1:0]       r_bcnt;
    logic [TW-1:0]       r_next;
    logic [TW-1:0]       r_ptr;
    logic [QW-1:0]       r_whead;
    logic [QW-1:0]       r_wtail;
    logic [QCW-1:0]      r_wcnt;
    logic [TW-1:0]       r_ftag;
    logic                r_tmo;
    logic [ID_WIDTH-1:0] r_own;

    logic [ID_WIDTH-1:0] r_own_mem [TAG_COUNT];
    logic [ID_WIDTH-1:0] r_wait_mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] r_own_rd;
    logic [ID_WIDTH-1:0] r_wait_rd;

    logic [ID_WIDTH-1:0] w_req;
    logic [TW-1:0]       w_itag;
    logic                w_found;
    logic [TW-1:0]       w_hit;
    logic [TW:0]         w_sum;
    logic [TW-1:0]       w_idx;
    logic [TW:0]         w_pnext;
    logic [TW:0]         w_tnext;
    logic                w_busy_all;

    assign w_req      = ID_WIDTH'(i_item.req);
    assign w_itag     = i_item.tag[TW-1:0];
    assign w_busy_all = (r_bcnt == BW'(TAG_COUNT));
    assign o_take     = (r_state == S_IDLE) && i_valid && i_room;

    // Window scan: first free tag among WIN tags from r_ptr, with wrap
    always_comb begin
        w_found = 1'b0;
        w_hit   = '0;
        w_sum   = '0;
        w_idx   = '0;
        for (int i = WIN - 1; i >= 0; i--) begin
            w_sum = {1'b0, r_ptr} + (TW+1)'(i);
            if (w_sum >= (TW+1)'(TAG_COUNT)) begin
                w_sum = w_sum - (TW+1)'(TAG_COUNT);
            end
            w_idx = w_sum[TW-1:0];
            if (!r_busy[w_idx]) begin
                w_found = 1'b1;
                w_hit   = w_idx;
            end
        end
        w_pnext = {1'b0, r_ptr} + (TW+1)'(WIN);
        if (w_pnext >= (TW+1)'(TAG_COUNT)) begin
            w_pnext = w_pnext - (TW+1)'(TAG_COUNT);
        end
        w_tnext = {1'b0, w_hit} + (TW+1)'(1);
        if (w_tnext >= (TW+1)'(TAG_COUNT)) begin
            w_tnext = w_tnext - (TW+1)'(TAG_COUNT);
        end
    end

    // Owner memory: write on claim, registered read on release
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && w_found) begin
            r_own_mem[w_hit] <= r_own;
        end
        if (o_take) begin
            r_own_rd <= r_own_mem[w_itag];
        end
    end

    // Wait queue memory: write on queue, registered read of the head
    always_ff @(posedge i_clk) begin
        if (o_take && i_item.cls.is_new && w_busy_all &&
            r_wcnt != QCW'(QUEUE_DEPTH)) begin
            r_wait_mem[r_wtail] <= w_req;
        end
        if (o_take) begin
            r_wait_rd <= r_wait_mem[r_whead];
        end
    end

    // Control and result generation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_bcnt      <= '0;
            r_next      <= '0;
            r_ptr       <= '0;
            r_whead     <= '0;
            r_wtail     <= '0;
            r_wcnt      <= '0;
            r_ftag      <= '0;
            r_tmo       <= 1'b0;
            r_own       <= '0;
            o_res_valid <= 1'b0;
            o_res       <= '0;
        end else begin
            o_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        if (i_item.cls.is_new) begin
                            if (!w_busy_all) begin
                                r_own   <= w_req;
                                r_ptr   <= r_next;
                                r_state <= S_SCAN;
                            end else if (r_wcnt != QCW'(QUEUE_DEPTH)) begin
                                r_wtail <= (r_wtail == QW'(QUEUE_DEPTH - 1)) ?
                                           '0 : r_wtail + QW'(1);
                                r_wcnt  <= r_wcnt + QCW'(1);
                                o_res_valid <= 1'b1;
                                o_res <= '{ev: ttag_pkg::EV_QUEUED, tag: '0,
                                           req: ttag_pkg::REQ_W'(w_req), last: 1'b1};
                            end else begin
                                o_res_valid <= 1'b1;
                                o_res <= '{ev: ttag_pkg::EV_DROPPED, tag: '0,
                                           req: ttag_pkg::REQ_W'(w_req), last: 1'b1};
                            end
                        end else if (i_item.cls.is_rel && r_busy[w_itag]) begin
                            r_busy[w_itag] <= 1'b0;
                            r_bcnt  <= r_bcnt - BW'(1);
                            r_ftag  <= w_itag;
                            r_tmo   <= i_item.cls.is_tmo;
                            r_state <= S_RDOWN;
                        end else begin
                            o_res_valid <= 1'b1;
                            o_res <= '{ev: ttag_pkg::EV_IGNORED, tag: i_item.tag,
                                       req: '0, last: 1'b1};
                        end
                    end
                end
                S_RDOWN: begin
                    o_res_valid <= 1'b1;
                    o_res <= '{ev: r_tmo ? ttag_pkg::EV_TIMED_OUT
                                         : ttag_pkg::EV_COMPLETED,
                               tag: ttag_pkg::TAG_W'(r_ftag),
                               req: ttag_pkg::REQ_W'(r_own_rd),
                               last: (r_wcnt == '0)};
                    if (r_wcnt != '0) begin
                        // Freed tag goes to the oldest waiter
                        r_own   <= r_wait_rd;
                        r_ptr   <= r_next;
                        r_whead <= (r_whead == QW'(QUEUE_DEPTH - 1)) ?
                                   '0 : r_whead + QW'(1);
                        r_wcnt  <= r_wcnt - QCW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (w_found) begin
                        r_busy[w_hit] <= 1'b1;
                        r_bcnt  <= r_bcnt + BW'(1);
                        r_next  <= w_tnext[TW-1:0];
                        o_res_valid <= 1'b1;
                        o_res <= '{ev: ttag_pkg::EV_ISSUED,
                                   tag: ttag_pkg::TAG_W'(w_hit),
                                   req: ttag_pkg::REQ_W'(r_own), last: 1'b1};
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= w_pnext[TW-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= BW'(TAG_COUNT)) else $error("back: busy count overflow");
    a_wcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= QCW'(QUEUE_DEPTH)) else $error("back: wait count overflow");
    a_wait_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_wcnt != '0) |-> (r_bcnt == BW'(TAG_COUNT)))
        else $error("back: waiter present while a tag is free");
    a_bcnt_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_busy) == int'(r_bcnt)))
        else $error("back: busy count disagrees with busy map");
`endif

endmodule

// ----- rtl/ttag_outq.sv -----
// ----------------------------------------------------------------------------
// ttag_outq
// Four-entry result queue; reports room for a two-result item.
// ----------------------------------------------------------------------------
module ttag_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  ttag_pkg::t_res i_res,
    output logic           o_room,
    output logic           o_empty,
    input  logic           i_pop,
    output ttag_pkg::t_res o_res
);

    localparam int DEPTH = 4;

    ttag_pkg::t_res r_q [DEPTH];
    logic [1:0]     r_head;
    logic [1:0]     r_tail;
    logic [2:0]     r_cnt;
    logic           w_rd;

    assign o_empty = (r_cnt == 3'd0);
    // A write landing this cycle already holds a slot
    assign o_room  = ((r_cnt + 3'(i_wr)) <= 3'(DEPTH - 2));
    assign o_res   = r_q[r_head];
    assign w_rd    = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_tail] <= i_res;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_tail <= r_tail + 2'd1;
            end
            if (w_rd) begin
                r_head <= r_head + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_wr) - 3'(w_rd);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_cnt < 3'(DEPTH) || w_rd)) else $error("outq: overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(DEPTH)) else $error("outq: count out of range");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 3'd1))
        else $error("outq: count not tracking write");
`endif

endmodule

// ----- rtl/transaction_tag_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// transaction_tag_allocator_unit
// Usage: items enter through a queue-style port (push/full) carrying command,
// tag and request_id. Results leave through a queue-style port (empty/pop):
// the oldest result is on o_event_res, o_out_tag, o_out_request and o_last
// while empty is low; o_last marks the final result of an item.
// A new request is issued with the first free tag scanning forward from the
// rotating pointer, queued when all tags are busy, or dropped when the wait
// queue is full. A response or timeout frees a busy tag, then hands it to the
// oldest waiter (two results); unknown tags are ignored.
// Sequence: ignore, queue and drop emit their result straight from idle; an
// issue passes through the scan state, which repeats (16 tags checked per
// cycle over the busy map) until a free tag is found; a release emits its
// first result from the read-down state, then the waiter's issue.
// The engine handles one item at a time and takes no new item until it is
// back in idle with room for two results in the result queue.
// Reset clears the busy map, pointers and queues; no clearing pass is needed.
// A stalled receiver fills the four-entry result queue; the engine stops taking
// items once fewer than two slots are free, and full rises once the two-entry input queue fills.
// ----------------------------------------------------------------------------
module transaction_tag_allocator_unit #(
    parameter int TAG_COUNT   = ttag_pkg::TAG_COUNT_DEF,
    parameter int QUEUE_DEPTH = ttag_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ttag_pkg::ID_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [ttag_pkg::CMD_W-1:0]     i_command,
    input  logic [ttag_pkg::TAG_W-1:0]     i_tag,
    input  logic [ttag_pkg::REQ_W-1:0]     i_request_id,
    output logic                           empty,
    input  logic                           pop,
    output logic [ttag_pkg::EVENT_W-1:0]   o_event_res,
    output logic [ttag_pkg::TAG_W-1:0]     o_out_tag,
    output logic [ttag_pkg::REQ_W-1:0]     o_out_request,
    output logic                           o_last
);

    logic            w_fvalid;
    ttag_pkg::t_item w_item;
    logic            w_take;
    logic            w_room;
    logic            w_rvalid;
    ttag_pkg::t_res  w_res;
    ttag_pkg::t_res  w_out;

    // Front end: input queue and classification
    ttag_front #(.TAG_COUNT(TAG_COUNT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_command    (i_command),
        .i_tag        (i_tag),
        .i_request_id (i_request_id),
        .o_valid      (w_fvalid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    // Back end: allocation engine
    ttag_back #(
        .TAG_COUNT   (TAG_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_fvalid),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_room      (w_room),
        .o_res_valid (w_rvalid),
        .o_res       (w_res)
    );

    // Result queue
    ttag_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_rvalid),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_out)
    );

    assign o_event_res   = w_out.ev;
    assign o_out_tag     = w_out.tag;
    assign o_out_request = w_out.req;
    assign o_last        = w_out.last;

endmodule
